[rtl/lot_pkg.sv]
// ----------------------------------------------------------------------------
// Layer order table package
// Types, widths and codes shared by the controller, the datapath and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package lot_pkg;

   localparam int HANDLE_W = 5;
   localparam int ACTION_W = 3;
   // Wide enough to compare a handle against a count that may reach 32.
   localparam int CMP_W    = HANDLE_W + 1;
   localparam int HANDLE_SPAN = 2 ** HANDLE_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND = 3'd0,
      ACT_TOP    = 3'd1,
      ACT_BOTTOM = 3'd2,
      ACT_UP     = 3'd3,
      ACT_DOWN   = 3'd4,
      ACT_ABOVE  = 3'd5,
      ACT_BELOW  = 3'd6,
      ACT_READ   = 3'd7
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_WAIT,
      ST_SRC_WAIT,
      ST_TGT_WAIT,
      ST_CALC,
      ST_SHIFT_START,
      ST_SHIFT,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef enum logic {
      RR_HDL,
      RR_TGT
   } roh_rsel_type;

   typedef enum logic [1:0] {
      HR_HDL,
      HR_NEXT,
      HR_NEXT2
   } har_rsel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_APPEND,
      WR_SHIFT,
      WR_FIN
   } wr_sel_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_APPEND,
      RES_READ,
      RES_MOVE
   } res_sel_type;

   typedef struct packed {
      logic         load;
      roh_rsel_type roh_rsel;
      har_rsel_type har_rsel;
      wr_sel_type   wr_sel;
      logic         cap_src;
      logic         cap_tgt;
      logic         set_dest;
      logic         step;
      res_sel_type  res_sel;
      logic         post;
   } cmd_type;

   typedef struct packed {
      action_type act;
      logic       full;
      logic       h_ok;
      logic       t_ok;
      logic       go;
      logic       at_dest;
      logic       last;
      logic       out_busy;
   } sts_type;

endpackage

`default_nettype wire

[rtl/layer_order_table_core.sv]
// ----------------------------------------------------------------------------
// Layer order table core
// Stacking order over layer handles, kept as a rank map and its inverse.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                                      | Direction
//   --------+--------------------------------------------+----------
//   request | req_valid, req_stall, req_action,          | in
//           | req_handle, req_target                     |
//   result  | rsp_valid, rsp_stall, rsp_ok,              | out
//           | rsp_handle_out, rsp_new_rank               |
//
// One request is handled at a time. Append, read and refused requests post
// their result without a shift walk. A move that leaves its rank unchanged
// goes straight to the final write; any other move first shifts each rank
// between source and destination by one. The next request is taken the cycle
// after the result is posted. Reset clears the entry count, the result valid
// flag and the controller state; the maps need no clearing pass. A stalled
// result holds the block in its final state until it is taken.

`default_nettype none

module layer_order_table_core #(
   parameter int MAX_LAYERS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [lot_pkg::ACTION_W-1:0] req_action,
   input  wire logic [lot_pkg::HANDLE_W-1:0] req_handle,
   input  wire logic [lot_pkg::HANDLE_W-1:0] req_target,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_ok,
   output logic [lot_pkg::HANDLE_W-1:0]      rsp_handle_out,
   output logic [lot_pkg::HANDLE_W-1:0]      rsp_new_rank
);

   lot_pkg::cmd_type cmd;
   lot_pkg::sts_type sts;

   lot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lot_dp #(
      .MAX_LAYERS (MAX_LAYERS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_handle     (req_handle),
      .req_target     (req_target),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_handle_out (rsp_handle_out),
      .rsp_new_rank   (rsp_new_rank)
   );

   // An accepted request blocks the next one until its result is posted.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one still in progress");

   // A refused request reports nothing but zeros.
   a_refusal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_handle_out == '0) && (rsp_new_rank == '0))
      else $error("refused result carries non-zero fields");

   // A new result only appears while a request is being worked on.
   a_result_needs_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result posted without a request in progress");

endmodule

`default_nettype wire

[rtl/lot_ctrl.sv]
// ----------------------------------------------------------------------------
// Layer order table controller
// Sequences lookups, the rank shift walk and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lot_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lot_pkg::sts_type sts,
   output lot_pkg::cmd_type      cmd
);

   lot_pkg::state_type state_ff;
   lot_pkg::state_type state_in;
   logic               is_place;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lot_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign is_place  = (sts.act == lot_pkg::ACT_ABOVE) || (sts.act == lot_pkg::ACT_BELOW);
   assign req_stall = (state_ff != lot_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.roh_rsel = lot_pkg::RR_HDL;
      cmd.har_rsel = lot_pkg::HR_HDL;
      cmd.wr_sel   = lot_pkg::WR_NONE;
      cmd.res_sel  = lot_pkg::RES_NONE;
      unique case (state_ff)
         lot_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = lot_pkg::ST_DECODE;
            end
         end
         lot_pkg::ST_DECODE: begin
            unique case (sts.act)
               lot_pkg::ACT_APPEND: begin
                  if (!sts.full) begin
                     cmd.wr_sel  = lot_pkg::WR_APPEND;
                     cmd.res_sel = lot_pkg::RES_APPEND;
                  end
                  state_in = lot_pkg::ST_DONE;
               end
               lot_pkg::ACT_READ: begin
                  if (sts.h_ok) begin
                     cmd.har_rsel = lot_pkg::HR_HDL;
                     state_in     = lot_pkg::ST_READ_WAIT;
                  end else begin
                     state_in = lot_pkg::ST_DONE;
                  end
               end
               default: begin
                  if (sts.h_ok) begin
                     cmd.roh_rsel = lot_pkg::RR_HDL;
                     state_in     = lot_pkg::ST_SRC_WAIT;
                  end else begin
                     state_in = lot_pkg::ST_DONE;
                  end
               end
            endcase
         end
         lot_pkg::ST_READ_WAIT: begin
            cmd.res_sel = lot_pkg::RES_READ;
            state_in    = lot_pkg::ST_DONE;
         end
         lot_pkg::ST_SRC_WAIT: begin
            cmd.cap_src = 1'b1;
            if (is_place) begin
               if (sts.t_ok) begin
                  cmd.roh_rsel = lot_pkg::RR_TGT;
                  state_in     = lot_pkg::ST_TGT_WAIT;
               end else begin
                  state_in = lot_pkg::ST_DONE;
               end
            end else begin
               state_in = lot_pkg::ST_CALC;
            end
         end
         lot_pkg::ST_TGT_WAIT: begin
            cmd.cap_tgt = 1'b1;
            state_in    = lot_pkg::ST_CALC;
         end
         lot_pkg::ST_CALC: begin
            if (sts.go) begin
               cmd.set_dest = 1'b1;
               cmd.res_sel  = lot_pkg::RES_MOVE;
               state_in     = sts.at_dest ? lot_pkg::ST_FIN : lot_pkg::ST_SHIFT_START;
            end else begin
               state_in = lot_pkg::ST_DONE;
            end
         end
         lot_pkg::ST_SHIFT_START: begin
            cmd.har_rsel = lot_pkg::HR_NEXT;
            state_in     = lot_pkg::ST_SHIFT;
         end
         lot_pkg::ST_SHIFT: begin
            // The neighbour read last cycle is written one rank towards the
            // vacated place while the one after it is fetched.
            cmd.wr_sel = lot_pkg::WR_SHIFT;
            cmd.step   = 1'b1;
            if (sts.last) begin
               state_in = lot_pkg::ST_FIN;
            end else begin
               cmd.har_rsel = lot_pkg::HR_NEXT2;
            end
         end
         lot_pkg::ST_FIN: begin
            cmd.wr_sel = lot_pkg::WR_FIN;
            state_in   = lot_pkg::ST_DONE;
         end
         lot_pkg::ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.post = 1'b1;
               state_in = lot_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lot_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/lot_dp.sv]
// ----------------------------------------------------------------------------
// Layer order table datapath
// Rank and handle maps, request registers, shift walker and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lot_dp #(
   parameter int MAX_LAYERS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [lot_pkg::ACTION_W-1:0]  req_action,
   input  wire logic [lot_pkg::HANDLE_W-1:0]  req_handle,
   input  wire logic [lot_pkg::HANDLE_W-1:0]  req_target,
   input  wire lot_pkg::cmd_type              cmd,
   output lot_pkg::sts_type                   sts,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_ok,
   output logic [lot_pkg::HANDLE_W-1:0]       rsp_handle_out,
   output logic [lot_pkg::HANDLE_W-1:0]       rsp_new_rank
);

   localparam int LIMIT = (MAX_LAYERS < lot_pkg::HANDLE_SPAN) ? MAX_LAYERS
                                                              : lot_pkg::HANDLE_SPAN;
   localparam int AW    = $clog2(LIMIT);
   localparam int CW    = $clog2(LIMIT + 1);
   localparam int HW    = lot_pkg::HANDLE_W;
   localparam int XW    = lot_pkg::CMP_W;

   logic [HW-1:0] roh_mem [LIMIT];
   logic [HW-1:0] har_mem [LIMIT];

   lot_pkg::action_type act_ff;
   logic [HW-1:0]       hdl_ff;
   logic [HW-1:0]       tgt_ff;
   logic [CW-1:0]       cnt_ff;
   logic [AW-1:0]       rs_ff;
   logic [AW-1:0]       rd_ff;
   logic [AW-1:0]       dest_ff;
   logic [AW-1:0]       k_ff;
   logic                up_ff;
   logic [HW-1:0]       roh_q_ff;
   logic [HW-1:0]       har_q_ff;
   logic                res_ok_ff;
   logic [HW-1:0]       res_hout_ff;
   logic [HW-1:0]       res_rank_ff;
   logic                rsp_valid_ff;
   logic                rsp_ok_ff;
   logic [HW-1:0]       rsp_hout_ff;
   logic [HW-1:0]       rsp_rank_ff;

   logic [AW-1:0] roh_raddr;
   logic [AW-1:0] har_raddr;
   logic [AW-1:0] k_next;
   logic [AW-1:0] k_next2;
   logic [XW-1:0] rs_x;
   logic [XW-1:0] rd_x;
   logic [XW-1:0] n_x;
   logic [XW-1:0] dest_x;
   logic [AW-1:0] dest_calc;
   logic          go_calc;

   assign k_next  = up_ff ? (k_ff + 1'b1) : (k_ff - 1'b1);
   assign k_next2 = up_ff ? (k_next + 1'b1) : (k_next - 1'b1);

   assign rs_x = XW'(rs_ff);
   assign rd_x = XW'(rd_ff);
   assign n_x  = XW'(cnt_ff);

   always_comb begin
      dest_x  = '0;
      go_calc = 1'b1;
      unique case (act_ff)
         lot_pkg::ACT_TOP:    dest_x = n_x - 1'b1;
         lot_pkg::ACT_BOTTOM: dest_x = '0;
         lot_pkg::ACT_UP: begin
            dest_x  = rs_x + 1'b1;
            go_calc = (dest_x < n_x);
         end
         lot_pkg::ACT_DOWN: begin
            dest_x  = rs_x - 1'b1;
            go_calc = (rs_ff != '0);
         end
         lot_pkg::ACT_ABOVE:  dest_x = (rs_ff < rd_ff) ? rd_x : (rd_x + 1'b1);
         lot_pkg::ACT_BELOW:  dest_x = (rs_ff < rd_ff) ? (rd_x - 1'b1) : rd_x;
         default: begin
            dest_x  = '0;
            go_calc = 1'b0;
         end
      endcase
      dest_calc = dest_x[AW-1:0];
   end

   always_comb begin
      unique case (cmd.roh_rsel)
         lot_pkg::RR_HDL: roh_raddr = hdl_ff[AW-1:0];
         lot_pkg::RR_TGT: roh_raddr = tgt_ff[AW-1:0];
         default:         roh_raddr = hdl_ff[AW-1:0];
      endcase
      unique case (cmd.har_rsel)
         lot_pkg::HR_HDL:   har_raddr = hdl_ff[AW-1:0];
         lot_pkg::HR_NEXT:  har_raddr = k_next;
         lot_pkg::HR_NEXT2: har_raddr = k_next2;
         default:           har_raddr = hdl_ff[AW-1:0];
      endcase
   end

   // Both maps have one write port and one registered read port.
   always_ff @(posedge clock) begin
      roh_q_ff <= roh_mem[roh_raddr];
      har_q_ff <= har_mem[har_raddr];
      unique case (cmd.wr_sel)
         lot_pkg::WR_APPEND: begin
            roh_mem[cnt_ff[AW-1:0]] <= HW'(cnt_ff);
            har_mem[cnt_ff[AW-1:0]] <= HW'(cnt_ff);
         end
         lot_pkg::WR_SHIFT: begin
            har_mem[k_ff]               <= har_q_ff;
            roh_mem[har_q_ff[AW-1:0]]   <= HW'(k_ff);
         end
         lot_pkg::WR_FIN: begin
            har_mem[dest_ff]            <= hdl_ff;
            roh_mem[hdl_ff[AW-1:0]]     <= HW'(dest_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= lot_pkg::action_type'(req_action);
         hdl_ff <= req_handle;
         tgt_ff <= req_target;
      end
      if (cmd.cap_src) begin
         rs_ff <= roh_q_ff[AW-1:0];
      end
      if (cmd.cap_tgt) begin
         rd_ff <= roh_q_ff[AW-1:0];
      end
      if (cmd.set_dest) begin
         dest_ff <= dest_calc;
         k_ff    <= rs_ff;
         up_ff   <= (rs_ff < dest_calc);
      end else if (cmd.step) begin
         k_ff <= k_next;
      end
      if (cmd.post) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_hout_ff <= res_hout_ff;
         rsp_rank_ff <= res_rank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_ok_ff   <= 1'b0;
         res_hout_ff <= '0;
         res_rank_ff <= '0;
      end else begin
         unique case (cmd.res_sel)
            lot_pkg::RES_APPEND: begin
               res_ok_ff   <= 1'b1;
               res_hout_ff <= HW'(cnt_ff);
               res_rank_ff <= HW'(cnt_ff);
            end
            lot_pkg::RES_READ: begin
               res_ok_ff   <= 1'b1;
               res_hout_ff <= har_q_ff;
            end
            lot_pkg::RES_MOVE: begin
               res_ok_ff   <= 1'b1;
               res_rank_ff <= HW'(dest_calc);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_sel == lot_pkg::WR_APPEND) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.post) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.act      = act_ff;
   assign sts.full     = (cnt_ff == CW'(LIMIT));
   assign sts.h_ok     = (XW'(hdl_ff) < n_x);
   assign sts.t_ok     = (XW'(tgt_ff) < n_x) && (tgt_ff != hdl_ff);
   assign sts.go       = go_calc;
   assign sts.at_dest  = (dest_calc == rs_ff);
   assign sts.last     = (k_next == dest_ff);
   assign sts.out_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_handle_out = rsp_hout_ff;
   assign rsp_new_rank   = rsp_rank_ff;

endmodule

`default_nettype wire
